>>> hdl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths, pipeline depths and lane result types for the vector
// normalization block.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int MAG_W          = COMPONENT_BITS;
  localparam int SQ_W           = 2 * COMPONENT_BITS;
  localparam int SUM_W          = 2 * COMPONENT_BITS;
  localparam int ROOT_W         = COMPONENT_BITS;
  localparam int UNIT_W         = 16;
  localparam int UNIT_SH        = 2 * UNIT_W;
  localparam int LEN_W          = 16;
  localparam int ACC_W          = 2 * COMPONENT_BITS + 2 * UNIT_W + 4;
  localparam int LANE_STAGES    = (ROOT_W > UNIT_W) ? ROOT_W : UNIT_W;
  localparam int FRONT_STAGES   = 3;
  localparam int PIPE_STAGES    = FRONT_STAGES + LANE_STAGES;
  localparam longint unsigned LEN_MAX = 64'd65535;

  typedef struct packed {
    logic [UNIT_W-1:0] q;
    logic              neg;
  } unit_res_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rem;
    logic              zero;
  } root_res_t;

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic [LEN_W-1:0]  len;
    logic              zero;
  } result_t;

endpackage

>>> hdl/vn_sqrt_lane.sv
// ----------------------------------------------------------------------------
// vn_sqrt_lane
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt_lane (
  input  logic                              clk,
  input  logic [vn_pkg::LANE_STAGES-1:0]    en,
  input  logic [vn_pkg::SUM_W-1:0]          s,
  output vn_pkg::root_res_t                 res
);
  import vn_pkg::*;

  logic [ROOT_W-1:0] root_r [LANE_STAGES];
  logic [SUM_W-1:0]  rem_r  [LANE_STAGES];
  logic              zero_r [LANE_STAGES];

  for (genvar k = 0; k < LANE_STAGES; k++) begin : g_stage
    localparam int B = LANE_STAGES - 1 - k;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rem_in;
    logic              zero_in;
    logic [ROOT_W-1:0] root_nx;
    logic [SUM_W-1:0]  rem_nx;

    if (k == 0) begin : g_init
      assign root_in = '0;
      assign rem_in  = s;
      assign zero_in = (s == '0);
    end else begin : g_chain
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign zero_in = zero_r[k-1];
    end

    if (B < ROOT_W) begin : g_step
      logic [SUM_W+1:0] trial;
      always_comb begin
        trial = ((SUM_W+2)'(root_in) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
        if ((SUM_W+2)'(rem_in) >= trial) begin
          rem_nx  = SUM_W'((SUM_W+2)'(rem_in) - trial);
          root_nx = root_in | (ROOT_W'(1) << B);
        end else begin
          rem_nx  = rem_in;
          root_nx = root_in;
        end
      end
    end else begin : g_pass
      assign rem_nx  = rem_in;
      assign root_nx = root_in;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        root_r[k] <= root_nx;
        rem_r[k]  <= rem_nx;
        zero_r[k] <= zero_in;
      end
    end
  end

  assign res.root = root_r[LANE_STAGES-1];
  assign res.rem  = rem_r[LANE_STAGES-1];
  assign res.zero = zero_r[LANE_STAGES-1];

endmodule

>>> hdl/vn_unit_lane.sv
// ----------------------------------------------------------------------------
// vn_unit_lane
// Pipelined quotient search for one component, one quotient bit per stage.
// The trial square (2q-1)^2 * s is kept up to date with shifts and adds.
// ----------------------------------------------------------------------------
module vn_unit_lane (
  input  logic                              clk,
  input  logic [vn_pkg::LANE_STAGES-1:0]    en,
  input  logic [vn_pkg::SUM_W-1:0]          s,
  input  logic [vn_pkg::SQ_W-1:0]           sq,
  input  logic                              neg,
  output vn_pkg::unit_res_t                 res
);
  import vn_pkg::*;

  logic signed [ACC_W-1:0] p_r   [LANE_STAGES];
  logic signed [ACC_W-1:0] a_r   [LANE_STAGES];
  logic [SUM_W-1:0]        s_r   [LANE_STAGES];
  logic [SQ_W-1:0]         sq_r  [LANE_STAGES];
  logic [UNIT_W-1:0]       q_r   [LANE_STAGES];
  logic                    neg_r [LANE_STAGES];

  for (genvar k = 0; k < LANE_STAGES; k++) begin : g_stage
    localparam int B = LANE_STAGES - 1 - k;
    logic signed [ACC_W-1:0] p_in;
    logic signed [ACC_W-1:0] a_in;
    logic [SUM_W-1:0]        s_in;
    logic [SQ_W-1:0]         sq_in;
    logic [UNIT_W-1:0]       q_in;
    logic                    neg_in;
    logic signed [ACC_W-1:0] p_nx;
    logic signed [ACC_W-1:0] a_nx;
    logic [UNIT_W-1:0]       q_nx;

    if (k == 0) begin : g_init
      assign p_in   = signed'(ACC_W'(s));
      assign a_in   = -signed'(ACC_W'(s));
      assign s_in   = s;
      assign sq_in  = sq;
      assign q_in   = '0;
      assign neg_in = neg;
    end else begin : g_chain
      assign p_in   = p_r[k-1];
      assign a_in   = a_r[k-1];
      assign s_in   = s_r[k-1];
      assign sq_in  = sq_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    if (B < UNIT_W) begin : g_step
      logic signed [ACC_W-1:0] s_ext;
      logic signed [ACC_W-1:0] rhs;
      logic signed [ACC_W-1:0] cand;
      always_comb begin
        s_ext = signed'(ACC_W'(s_in));
        rhs   = signed'(ACC_W'(sq_in)) <<< UNIT_SH;
        cand  = p_in + (a_in <<< (B + 2)) + (s_ext <<< (2 * B + 2));
        if (cand <= rhs) begin
          p_nx = cand;
          a_nx = a_in + (s_ext <<< (B + 1));
          q_nx = q_in | (UNIT_W'(1) << B);
        end else begin
          p_nx = p_in;
          a_nx = a_in;
          q_nx = q_in;
        end
      end
    end else begin : g_pass
      assign p_nx = p_in;
      assign a_nx = a_in;
      assign q_nx = q_in;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        p_r[k]   <= p_nx;
        a_r[k]   <= a_nx;
        s_r[k]   <= s_in;
        sq_r[k]  <= sq_in;
        q_r[k]   <= q_nx;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign res.q   = q_r[LANE_STAGES-1];
  assign res.neg = neg_r[LANE_STAGES-1];

endmodule

>>> hdl/vn_merge.sv
// ----------------------------------------------------------------------------
// vn_merge
// Combines the lane results: length rounding and clamping, unit sign and
// saturation, and the zero vector case.
// ----------------------------------------------------------------------------
module vn_merge (
  input  vn_pkg::root_res_t  root,
  input  vn_pkg::unit_res_t  ux,
  input  vn_pkg::unit_res_t  uy,
  input  vn_pkg::unit_res_t  uz,
  output vn_pkg::result_t    res
);
  import vn_pkg::*;

  localparam logic [UNIT_W-1:0] MAG_NEG = UNIT_W'(1) << (UNIT_W - 1);
  localparam logic [UNIT_W-1:0] MAX_POS = MAG_NEG - UNIT_W'(1);

  function automatic logic [UNIT_W-1:0] sat_unit(unit_res_t u);
    logic [UNIT_W-1:0] qs;
    if (u.neg) begin
      qs = (u.q > MAG_NEG) ? MAG_NEG : u.q;
      return UNIT_W'(~qs + UNIT_W'(1));
    end
    return (u.q > MAX_POS) ? MAX_POS : u.q;
  endfunction

  logic [ROOT_W:0] len_full;

  always_comb begin
    if (root.rem > SUM_W'(root.root)) begin
      len_full = {1'b0, root.root} + (ROOT_W+1)'(1);
    end else begin
      len_full = {1'b0, root.root};
    end
    if (root.zero) begin
      res = '0;
      res.zero = 1'b1;
    end else begin
      res.ux   = sat_unit(ux);
      res.uy   = sat_unit(uy);
      res.uz   = sat_unit(uz);
      res.len  = (64'(len_full) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(len_full);
      res.zero = 1'b0;
    end
  end

endmodule

>>> hdl/vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Normalizes a three-component signed vector and reports its rounded length.
// ----------------------------------------------------------------------------
// The block accepts one vector per clock while the output side does not
// stall. A result passes these registers in order: the magnitudes are
// registered at the transfer edge itself, then one stage for the squares, one
// for the sum, sixteen lane stages that each settle one bit of the root and of
// the three quotients, and the output register. Stages hold their data
// independently, so a stalled output only stops the stages that are full
// behind it.
// ----------------------------------------------------------------------------
module vector3_normalize_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vn_pkg::MAG_W-1:0]       comp_x,
  input  logic signed [vn_pkg::MAG_W-1:0]       comp_y,
  input  logic signed [vn_pkg::MAG_W-1:0]       comp_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vn_pkg::UNIT_W-1:0]      unit_x,
  output logic signed [vn_pkg::UNIT_W-1:0]      unit_y,
  output logic signed [vn_pkg::UNIT_W-1:0]      unit_z,
  output logic [vn_pkg::LEN_W-1:0]              vec_length,
  output logic                                  zero_length
);
  import vn_pkg::*;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES:0]   en;

  logic [MAG_W-1:0] mag_x, mag_y, mag_z;
  logic             neg0_x, neg0_y, neg0_z;
  logic [SQ_W-1:0]  sq1_x, sq1_y, sq1_z;
  logic             neg1_x, neg1_y, neg1_z;
  logic [SQ_W-1:0]  sq2_x, sq2_y, sq2_z;
  logic             neg2_x, neg2_y, neg2_z;
  logic [SUM_W-1:0] sum2;

  root_res_t root_res;
  unit_res_t res_x, res_y, res_z;
  result_t   merged;

  always_comb begin
    en[PIPE_STAGES] = !out_valid || out_ready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (en[PIPE_STAGES]) begin
        out_valid <= v[PIPE_STAGES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0_x <= comp_x[MAG_W-1];
      neg0_y <= comp_y[MAG_W-1];
      neg0_z <= comp_z[MAG_W-1];
      mag_x  <= comp_x[MAG_W-1] ? MAG_W'(-comp_x) : MAG_W'(comp_x);
      mag_y  <= comp_y[MAG_W-1] ? MAG_W'(-comp_y) : MAG_W'(comp_y);
      mag_z  <= comp_z[MAG_W-1] ? MAG_W'(-comp_z) : MAG_W'(comp_z);
    end
    if (en[1]) begin
      sq1_x  <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq1_y  <= SQ_W'(mag_y) * SQ_W'(mag_y);
      sq1_z  <= SQ_W'(mag_z) * SQ_W'(mag_z);
      neg1_x <= neg0_x;
      neg1_y <= neg0_y;
      neg1_z <= neg0_z;
    end
    if (en[2]) begin
      sum2   <= SUM_W'(sq1_x) + SUM_W'(sq1_y) + SUM_W'(sq1_z);
      sq2_x  <= sq1_x;
      sq2_y  <= sq1_y;
      sq2_z  <= sq1_z;
      neg2_x <= neg1_x;
      neg2_y <= neg1_y;
      neg2_z <= neg1_z;
    end
  end

  vn_sqrt_lane u_sqrt (
    .clk (clk),
    .en  (en[PIPE_STAGES-1:FRONT_STAGES]),
    .s   (sum2),
    .res (root_res)
  );

  vn_unit_lane u_lane_x (
    .clk (clk),
    .en  (en[PIPE_STAGES-1:FRONT_STAGES]),
    .s   (sum2),
    .sq  (sq2_x),
    .neg (neg2_x),
    .res (res_x)
  );

  vn_unit_lane u_lane_y (
    .clk (clk),
    .en  (en[PIPE_STAGES-1:FRONT_STAGES]),
    .s   (sum2),
    .sq  (sq2_y),
    .neg (neg2_y),
    .res (res_y)
  );

  vn_unit_lane u_lane_z (
    .clk (clk),
    .en  (en[PIPE_STAGES-1:FRONT_STAGES]),
    .s   (sum2),
    .sq  (sq2_z),
    .neg (neg2_z),
    .res (res_z)
  );

  vn_merge u_merge (
    .root (root_res),
    .ux   (res_x),
    .uy   (res_y),
    .uz   (res_z),
    .res  (merged)
  );

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES]) begin
      unit_x      <= signed'(merged.ux);
      unit_y      <= signed'(merged.uy);
      unit_z      <= signed'(merged.uz);
      vec_length  <= merged.len;
      zero_length <= merged.zero;
    end
  end

  // An empty output register never holds back a new transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while output register is empty");

  a_zero_outputs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_length) |->
      (unit_x == '0 && unit_y == '0 && unit_z == '0 && vec_length == '0))
    else $error("zero vector result carries nonzero fields");

  a_nonzero_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_length) |-> (vec_length != '0))
    else $error("nonzero vector reported with zero length");

endmodule

>>> sim/vector3_normalize_checker.sv
// ----------------------------------------------------------------------------
// vector3_normalize_checker
// Watches both channels of the vector normalization block, computes the
// expected length and unit vector of every accepted input and compares each
// output transfer with the oldest pending expectation.
// ----------------------------------------------------------------------------
module vector3_normalize_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [vn_pkg::MAG_W-1:0]  comp_x,
  input  logic signed [vn_pkg::MAG_W-1:0]  comp_y,
  input  logic signed [vn_pkg::MAG_W-1:0]  comp_z,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [vn_pkg::UNIT_W-1:0] unit_x,
  input  logic signed [vn_pkg::UNIT_W-1:0] unit_y,
  input  logic signed [vn_pkg::UNIT_W-1:0] unit_z,
  input  logic [vn_pkg::LEN_W-1:0]         vec_length,
  input  logic                             zero_length,
  output int                               fail_count,
  output int                               pending_count
);

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic [15:0] len;
    logic        zero;
  } norm_t;

  norm_t pending_norms[$];

  function automatic logic [15:0] unit_of(logic signed [15:0] c, logic [33:0] s);
    logic [15:0]  mag;
    logic [127:0] lim;
    logic [16:0]  q;
    logic [16:0]  t;
    logic [33:0]  d;
    mag = c[15] ? 16'(-c) : 16'(c);
    if (c == -16'sd32768) mag = 16'h8000;
    lim = {96'd0, 32'(mag) * 32'(mag)} << 32;
    q = 0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (17'd1 << b);
      d = 34'(2 * t) - 34'd1;
      if (128'(d) * 128'(d) * 128'(s) <= lim) q = t;
    end
    if (c[15]) begin
      if (q > 17'd32768) q = 17'd32768;
      return 16'(17'h10000 - q);
    end
    if (q > 17'd32767) q = 17'd32767;
    return q[15:0];
  endfunction

  function automatic norm_t normalize(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z);
    norm_t r;
    logic [33:0] s;
    logic [33:0] root;
    s = 34'(34'(x) * 34'(x) + 34'(y) * 34'(y) + 34'(z) * 34'(z));
    r = '0;
    if (s == 0) begin
      r.zero = 1'b1;
      return r;
    end
    root = 0;
    for (int b = 16; b >= 0; b--)
      if ((root | (34'd1 << b)) * (root | (34'd1 << b)) <= s) root = root | (34'd1 << b);
    if (s - root * root > root) root = root + 1;
    r.len = (root > 34'd65535) ? 16'hFFFF : root[15:0];
    r.ux = unit_of(x, s);
    r.uy = unit_of(y, s);
    r.uz = unit_of(z, s);
    return r;
  endfunction

  assign pending_count = pending_norms.size();

  always @(posedge clk) begin
    norm_t exp_n;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) pending_norms.push_back(normalize(comp_x, comp_y, comp_z));
      if (out_valid && out_ready) begin
        if (pending_norms.size() == 0) begin
          $display("%0t: unexpected transfer ux=%0d uy=%0d uz=%0d len=%0d zero=%0b",
                   $time, unit_x, unit_y, unit_z, vec_length, zero_length);
          fail_count <= fail_count + 1;
        end else begin
          exp_n = pending_norms.pop_front();
          if (exp_n != {unit_x, unit_y, unit_z, vec_length, zero_length}) begin
            $display("%0t: expected ux=%0d uy=%0d uz=%0d len=%0d zero=%0b, got ux=%0d uy=%0d uz=%0d len=%0d zero=%0b",
                     $time, $signed(exp_n.ux), $signed(exp_n.uy), $signed(exp_n.uz),
                     exp_n.len, exp_n.zero, unit_x, unit_y, unit_z, vec_length,
                     zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize_top
// Drives directed and random vectors into the normalization block in bursts,
// stalls the output side on its own pattern including one long hold-off, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] comp_x = '0;
  logic signed [15:0] comp_y = '0;
  logic signed [15:0] comp_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic [15:0]        vec_length;
  logic               zero_length;
  int                 fail_count;
  int                 pending_count;
  bit                 sending_done = 1'b0;

  always #5 clk = ~clk;

  vector3_normalize_top dut (.*);

  vector3_normalize_checker u_checker (.*);

  function automatic logic [15:0] random_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3)) - 16'd1;
      1: return 16'h8000 + 16'($urandom_range(0, 3));
      2: return 16'h7FFF - 16'($urandom_range(0, 3));
      3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] dir_vec[20][3] = '{
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h7FFF, 16'h0000, 16'h0000},
      '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h8000, 16'h0000},
      '{16'h0000, 16'h0000, 16'h8000}, '{16'h0000, 16'h7FFF, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0001}, '{16'hFFFF, 16'h0000, 16'h0000},
      '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
      '{16'h7FFF, 16'h8000, 16'h7FFF}, '{16'h0003, 16'h0004, 16'h0000},
      '{16'hFFFD, 16'h0004, 16'h000C}, '{16'h0001, 16'h0001, 16'h0001},
      '{16'h0001, 16'h0001, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'h0002, 16'h0000, 16'h0001}, '{16'h5555, 16'hAAAA, 16'h0000},
      '{16'h0000, 16'h0001, 16'h8000}, '{16'h1234, 16'hEDCB, 16'h7000}};
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_vec[i]) send_vector(dir_vec[i][0], dir_vec[i][1], dir_vec[i][2]);
    for (int n = 0; n < 1500; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++)
        send_vector(random_comp(), random_comp(), random_comp());
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    @(negedge clk iff !rst);
    repeat (60) @(negedge clk);
    out_ready <= 1'b0;
    repeat (200) @(negedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  initial begin
    wait (sending_done);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
